// ===== sv/cfsd_pkg.sv =====
// Shared types, constants and frame assembly for the checksum frame deframer.
package cfsd_pkg;

    localparam int DATA_BYTES   = 8;
    localparam int WINDOW_DEPTH = 8;
    localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int WORD_BYTES   = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SEED_RESET = 8'hAA;

    typedef logic [7:0] byte_t;
    typedef byte_t [WINDOW_DEPTH-1:0] window_t;

    typedef struct packed {
        logic signed [31:0] first_word;
        logic signed [31:0] second_word;
    } frame_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    function automatic byte_t frame_byte(input window_t win, input int pos);
        byte_t b;
        b = '0;
        if (pos < DATA_BYTES && pos < WINDOW_DEPTH)
        begin
            b = win[pos];
        end
        return b;
    endfunction

    function automatic logic [31:0] assemble_word(input window_t win, input int base);
        logic [31:0] w;
        w = {frame_byte(win, base), frame_byte(win, base + 1),
             frame_byte(win, base + 2), frame_byte(win, base + 3)};
        return w;
    endfunction

endpackage

// ===== sv/cfsd_byte_if.sv =====
// Byte request channel: valid, ready and one received serial byte.
interface cfsd_byte_if;
    logic                valid;
    logic                ready;
    cfsd_pkg::byte_t     rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/cfsd_frame_if.sv =====
// Frame request channel: valid, ready and the two assembled frame words.
interface cfsd_frame_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_word;
    logic signed [31:0] second_word;

    modport source (output valid, output first_word, output second_word, input ready);
    modport sink   (input valid, input first_word, input second_word, output ready);
endinterface

// ===== sv/cfsd_front.sv =====
// Front end: byte window, running sum, checksum match and frame push.
module cfsd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    cfsd_byte_if.sink             rx,
    input  logic                  seed_we,
    input  logic [7:0]            seed_wdata,
    input  cfsd_pkg::q_status_t   q_status,
    output logic                  push,
    output cfsd_pkg::frame_t      push_frame
);

    logic [7:0]                   seed_reg;
    cfsd_pkg::window_t            win_reg;
    cfsd_pkg::window_t            win_next;
    logic [7:0]                   sum_reg;
    logic [7:0]                   sum_next;
    logic [cfsd_pkg::FILL_W-1:0]  fill_reg;
    logic [cfsd_pkg::FILL_W-1:0]  fill_next;
    logic                         accept;
    logic                         full;
    logic                         match;
    logic [7:0]                   expect_sum;

    localparam logic [cfsd_pkg::FILL_W-1:0] DEPTH =
        cfsd_pkg::FILL_W'(cfsd_pkg::DATA_BYTES);

    assign rx.ready   = !q_status.full;
    assign accept     = rx.valid && rx.ready;
    assign full       = (fill_reg >= DEPTH);
    assign expect_sum = seed_reg + sum_reg;
    assign match      = full && (rx.rx_byte == expect_sum);
    assign push       = accept && match;

    assign push_frame.first_word  = cfsd_pkg::assemble_word(win_reg, 0);
    assign push_frame.second_word = cfsd_pkg::assemble_word(win_reg, cfsd_pkg::WORD_BYTES);

    always_comb
    begin
        win_next  = win_reg;
        sum_next  = sum_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            if (match)
            begin
                win_next  = '0;
                sum_next  = '0;
                fill_next = '0;
            end
            else if (full)
            begin
                // slide: drop the oldest byte, append the new one at the top
                for (int i = 0; i < cfsd_pkg::WINDOW_DEPTH - 1; i++)
                begin
                    if (i < cfsd_pkg::DATA_BYTES - 1)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    else if (i == cfsd_pkg::DATA_BYTES - 1)
                    begin
                        win_next[i] = rx.rx_byte;
                    end
                end
                if (cfsd_pkg::DATA_BYTES == cfsd_pkg::WINDOW_DEPTH)
                begin
                    win_next[cfsd_pkg::WINDOW_DEPTH - 1] = rx.rx_byte;
                end
                sum_next = sum_reg - win_reg[0] + rx.rx_byte;
            end
            else
            begin
                win_next[fill_reg[cfsd_pkg::WIN_IDX_W-1:0]] = rx.rx_byte;
                sum_next  = sum_reg + rx.rx_byte;
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= cfsd_pkg::SEED_RESET;
            win_reg  <= '0;
            sum_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end
            win_reg  <= win_next;
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== sv/cfsd_queue.sv =====
// Two-entry frame queue between the front end and the output stage.
module cfsd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cfsd_pkg::frame_t      push_frame,
    input  logic                  pop,
    output cfsd_pkg::frame_t      head_frame,
    output cfsd_pkg::q_status_t   q_status
);

    cfsd_pkg::frame_t             mem_reg [cfsd_pkg::QUEUE_DEPTH];
    logic [cfsd_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [cfsd_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [cfsd_pkg::QCNT_W-1:0]  count_reg;
    logic [cfsd_pkg::QCNT_W-1:0]  count_next;

    localparam logic [cfsd_pkg::QCNT_W-1:0] FULL_COUNT =
        cfsd_pkg::QCNT_W'(cfsd_pkg::QUEUE_DEPTH);

    assign head_frame     = mem_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = (count_reg == FULL_COUNT);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/cfsd_back.sv =====
// Output stage: registered frame request toward the receiver.
module cfsd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfsd_pkg::q_status_t   q_status,
    input  cfsd_pkg::frame_t      head_frame,
    output logic                  pop,
    cfsd_frame_if.source          frames
);

    logic              out_valid_reg;
    logic              out_valid_next;
    cfsd_pkg::frame_t  out_frame_reg;

    assign pop            = q_status.valid && (!out_valid_reg || frames.ready);
    assign out_valid_next = pop || (out_valid_reg && !frames.ready);

    assign frames.valid       = out_valid_reg;
    assign frames.first_word  = out_frame_reg.first_word;
    assign frames.second_word = out_frame_reg.second_word;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_frame_reg <= head_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/checksum_frame_sync_deframer.sv =====
// Top level of the additive-checksum frame deframer.
//
// Usage: bytes from the serial receiver come in on rx, one per request.
// The block hunts for frames of 8 data bytes and a checksum byte equal to
// the seed plus the data byte sum (mod 256). Each frame found leaves on
// frames as two big-endian 32-bit words; a non-matching byte on a full
// window slides it by one. seed_we/seed_wdata load the seed; write it
// only while idle. Throughput: one byte per cycle; rx.ready drops only when
// the two-entry frame queue is full, which happens only while the receiver
// stalls frames. A frame is queued when its checksum byte is accepted and
// moves to the output register when that is empty or its frame is taken.
// A stalled receiver holds the output register, then fills the queue, then
// backpressures rx.
// Reset: the window, sum and byte count clear, the seed returns to 0xAA,
// the queue and output register empty. No warm-up pass.
module checksum_frame_sync_deframer (
    input  logic          clk,
    input  logic          rst_n,
    cfsd_byte_if.sink     rx,
    cfsd_frame_if.source  frames,
    input  logic          seed_we,
    input  logic [7:0]    seed_wdata
);

    logic                 push;
    logic                 pop;
    cfsd_pkg::frame_t     push_frame;
    cfsd_pkg::frame_t     head_frame;
    cfsd_pkg::q_status_t  q_status;

    cfsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .q_status   (q_status),
        .push       (push),
        .push_frame (push_frame)
    );

    cfsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_frame (head_frame),
        .q_status   (q_status)
    );

    cfsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_frame (head_frame),
        .pop        (pop),
        .frames     (frames)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full))
        else $error("frame pushed into a full queue");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.valid)
        else $error("pop from an empty queue");

    a_empty_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_status.valid && !push) |=> !q_status.valid)
        else $error("queue became non-empty without a push");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_status.valid)
        else $error("queue empty after a push");

endmodule

// ===== verif/cfsd_frame_checker.sv =====
`timescale 1ns / 1ps
// Frame checker: watches both channels and the seed port, predicts frames and compares them.
module cfsd_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    cfsd_byte_if        rx_mon,
    cfsd_frame_if       frames_mon,
    input  logic        seed_we,
    input  logic [7:0]  seed_wdata,
    output int          error_count,
    output int          pending_frames
);

    cfsd_pkg::byte_t   seed;
    cfsd_pkg::byte_t   win [cfsd_pkg::WINDOW_DEPTH];
    cfsd_pkg::byte_t   win_sum;
    int                held;
    int                errs;
    cfsd_pkg::frame_t  expected_frames [$];
    cfsd_pkg::frame_t  want;
    cfsd_pkg::frame_t  found;

    function automatic bit absorb_byte(input cfsd_pkg::byte_t b,
                                       output cfsd_pkg::frame_t f);
        bit hit;
        int i;
        hit = (held >= cfsd_pkg::DATA_BYTES) && (b == cfsd_pkg::byte_t'(seed + win_sum));
        f = '0;
        if (hit)
        begin
            for (i = 0; i < cfsd_pkg::WORD_BYTES; i++)
            begin
                f.first_word[31 - 8*i -: 8]  = (i < cfsd_pkg::DATA_BYTES) ? win[i] : 8'h00;
                f.second_word[31 - 8*i -: 8] =
                    (i + cfsd_pkg::WORD_BYTES < cfsd_pkg::DATA_BYTES) ?
                    win[i + cfsd_pkg::WORD_BYTES] : 8'h00;
            end
            for (i = 0; i < cfsd_pkg::WINDOW_DEPTH; i++)
            begin
                win[i] = 8'h00;
            end
            win_sum = 8'h00;
            held = 0;
        end
        else if (held >= cfsd_pkg::DATA_BYTES)
        begin
            // slide: drop the oldest byte, append the new one
            win_sum = cfsd_pkg::byte_t'(win_sum - win[0]);
            for (i = 0; i < cfsd_pkg::DATA_BYTES - 1; i++)
            begin
                win[i] = win[i + 1];
            end
            win[cfsd_pkg::DATA_BYTES - 1] = b;
            win_sum = cfsd_pkg::byte_t'(win_sum + b);
        end
        else
        begin
            win[held] = b;
            held++;
            win_sum = cfsd_pkg::byte_t'(win_sum + b);
        end
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed = cfsd_pkg::SEED_RESET;
            win_sum = 8'h00;
            held = 0;
            foreach (win[j])
            begin
                win[j] = 8'h00;
            end
            expected_frames.delete();
            errs = 0;
            error_count <= 0;
            pending_frames <= 0;
        end
        else
        begin
            if (frames_mon.valid && frames_mon.ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    errs++;
                    $error("unexpected frame: first_word %h, second_word %h",
                           frames_mon.first_word, frames_mon.second_word);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (frames_mon.first_word !== want.first_word)
                    begin
                        errs++;
                        $error("first_word: expected %h, actual %h",
                               want.first_word, frames_mon.first_word);
                    end
                    if (frames_mon.second_word !== want.second_word)
                    begin
                        errs++;
                        $error("second_word: expected %h, actual %h",
                               want.second_word, frames_mon.second_word);
                    end
                end
            end
            if (rx_mon.valid && rx_mon.ready)
            begin
                if (absorb_byte(rx_mon.rx_byte, found))
                begin
                    expected_frames.push_back(found);
                end
            end
            if (seed_we)
            begin
                seed = seed_wdata;
            end
            error_count <= errs;
            pending_frames <= expected_frames.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top: drives bytes, seed writes and backpressure into the deframer, gives the verdict.
module testbench;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 285;
    localparam int HOLD_CYCLES   = 60;

    logic        clk;
    logic        rst_n;
    logic        seed_we;
    logic [7:0]  seed_wdata;
    int          error_count;
    int          pending_frames;

    int               src_idle_pct;
    int               sink_stall_pct;
    bit               hold_go;
    int               hold_left;
    int               quiet_cycles;
    int               bytes_sent;
    int               phase_start;
    int               kind;
    int               p;
    bit               hold_done;
    cfsd_pkg::byte_t  seed_now;
    cfsd_pkg::byte_t  next_seed;
    cfsd_pkg::byte_t  frame_bytes [cfsd_pkg::DATA_BYTES];

    cfsd_byte_if  rx_if ();
    cfsd_frame_if frames_if ();

    checksum_frame_sync_deframer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_if),
        .frames     (frames_if),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata)
    );

    cfsd_frame_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_mon         (rx_if),
        .frames_mon     (frames_if),
        .seed_we        (seed_we),
        .seed_wdata     (seed_wdata),
        .error_count    (error_count),
        .pending_frames (pending_frames)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    task automatic send_byte(input cfsd_pkg::byte_t b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(negedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input cfsd_pkg::byte_t payload [cfsd_pkg::DATA_BYTES],
                              input cfsd_pkg::byte_t skew);
        cfsd_pkg::byte_t sum;
        sum = cfsd_pkg::byte_t'(seed_now + skew);
        for (int k = 0; k < cfsd_pkg::DATA_BYTES; k++)
        begin
            send_byte(payload[k]);
            sum = cfsd_pkg::byte_t'(sum + payload[k]);
        end
        send_byte(sum);
    endtask

    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        while (pending_frames != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        frames_if.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frames_if.ready <= 1'b0;
            end
            else
            begin
                frames_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((rx_if.valid && rx_if.ready) || (frames_if.valid && frames_if.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("** checksum_frame_sync_deframer: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = 8'h00;
        seed_we = 1'b0;
        seed_wdata = 8'h00;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_go = 1'b0;
        hold_done = 1'b0;
        bytes_sent = 0;
        seed_now = cfsd_pkg::SEED_RESET;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // match on a partly filled window: taken as data
        send_byte(cfsd_pkg::SEED_RESET);
        repeat (7) send_byte(8'h00);
        // mismatch on a full window: slide out the oldest byte
        send_byte(8'h00);
        send_byte(cfsd_pkg::SEED_RESET);
        foreach (frame_bytes[i])
        begin
            frame_bytes[i] = 8'hFF;
        end
        send_frame(frame_bytes, 8'h00);
        frame_bytes = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF};
        send_frame(frame_bytes, 8'h00);

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: next_seed = 8'h00;
                1: next_seed = 8'hFF;
                PHASES - 1: next_seed = cfsd_pkg::SEED_RESET;
                default: next_seed = cfsd_pkg::byte_t'($urandom_range(255));
            endcase
            wait_idle();
            seed_we <= 1'b1;
            seed_wdata <= next_seed;
            @(negedge clk);
            seed_we <= 1'b0;
            seed_now = next_seed;
            case (p % 4)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct <= 0;
                end
                1:
                begin
                    src_idle_pct = 84;
                    sink_stall_pct <= 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct <= 84;
                end
                default:
                begin
                    src_idle_pct = 37;
                    sink_stall_pct <= 37;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if (p == 0 && !hold_done && bytes_sent - phase_start >= 100)
                begin
                    hold_go <= 1'b1;
                    hold_done = 1'b1;
                end
                foreach (frame_bytes[i])
                begin
                    frame_bytes[i] = ($urandom_range(7) == 0) ?
                                     ($urandom_range(1) ? 8'hFF : 8'h00) :
                                     cfsd_pkg::byte_t'($urandom_range(255));
                end
                kind = $urandom_range(99);
                if (kind < 70)
                begin
                    send_frame(frame_bytes, 8'h00);
                end
                else if (kind < 85)
                begin
                    send_frame(frame_bytes, cfsd_pkg::byte_t'($urandom_range(255, 1)));
                end
                else
                begin
                    repeat ($urandom_range(10, 1))
                        send_byte(cfsd_pkg::byte_t'($urandom_range(255)));
                end
            end
        end

        wait_idle();
        if (error_count == 0 && pending_frames == 0)
        begin
            $display("** checksum_frame_sync_deframer: PASSED **");
        end
        else
        begin
            $display("** checksum_frame_sync_deframer: FAILED **");
        end
        $finish;
    end

endmodule
